/* src/thrm_pkg.sv */
// shared constants, types and table functions for the thermistor converter
package thrm_pkg;

    // field widths
    localparam int ADC_W  = 10;
    localparam int RES_W  = 26;
    localparam int TEMP_W = 16;
    localparam int CFG_AW = 4;

    // divider datapath widths
    localparam int NUM_W = 29;
    localparam int DEN_W = 13;
    localparam int TAG_W = 32;
    localparam int SEG_W = 5;

    // resistance table
    localparam int NPTS = 25;
    localparam int LAST = NPTS - 1;
    localparam int BASE_LAST = -40 + 5 * LAST;
    localparam logic [13:0] ROM [NPTS] = '{
        14'd8430, 14'd6230, 14'd4660, 14'd3520, 14'd2690, 14'd2080, 14'd1610,
        14'd1240, 14'd968,  14'd757,  14'd595,  14'd471,  14'd375,  14'd300,
        14'd242,  14'd196,  14'd159,  14'd131,  14'd108,  14'd89,   14'd74,
        14'd62,   14'd52,   14'd44,   14'd37
    };

    // register indexes
    localparam logic [1:0] REG_FULL     = 2'd0;
    localparam logic [1:0] REG_PULLUP   = 2'd1;
    localparam logic [1:0] REG_PULLDOWN = 2'd2;

    // divider input beat
    typedef struct packed {
        logic             vld;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [TAG_W-1:0] tag;
    } t_div_in;

    // divider output beat
    typedef struct packed {
        logic             vld;
        logic [NUM_W-1:0] quo;
        logic [TAG_W-1:0] tag;
    } t_div_out;

    // width of a table segment, the last one reuses the final segment
    function automatic logic [DEN_W-1:0] seg_den(input logic [SEG_W-1:0] s);
        logic [DEN_W-1:0] d;
        d = DEN_W'(ROM[LAST-1] - ROM[LAST]);
        for (int k = 0; k < LAST; k++) begin
            if (s == SEG_W'(k)) d = DEN_W'(ROM[k] - ROM[k+1]);
        end
        return d;
    endfunction

    // lower end of a table segment
    function automatic logic [13:0] seg_lo(input logic [SEG_W-1:0] s);
        logic [13:0] v;
        v = ROM[LAST];
        for (int k = 0; k < LAST; k++) begin
            if (s == SEG_W'(k)) v = ROM[k+1];
        end
        return v;
    endfunction

endpackage

/* src/thrm_div.sv */
// pipelined restoring divider, one quotient bit per stage, tag carried alongside
module thrm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  thrm_pkg::t_div_in  i_d,
    output thrm_pkg::t_div_out o_q
);

    localparam int NW = thrm_pkg::NUM_W;
    localparam int DW = thrm_pkg::DEN_W;
    localparam int TW = thrm_pkg::TAG_W;

    logic          r_vld [NW];
    logic [NW-1:0] r_acc [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [TW-1:0] r_tag [NW];

    logic          n_vld [NW];
    logic [NW-1:0] n_acc [NW];
    logic [DW-1:0] n_rem [NW];
    logic [DW-1:0] n_den [NW];
    logic [TW-1:0] n_tag [NW];

    // one compare and subtract per stage
    always_comb begin
        logic          v;
        logic [NW-1:0] a;
        logic [DW-1:0] r;
        logic [DW-1:0] d;
        logic [TW-1:0] t;
        logic [DW:0]   trial;
        logic          ge;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                v = i_d.vld;
                a = i_d.num;
                r = '0;
                d = i_d.den;
                t = i_d.tag;
            end else begin
                v = r_vld[k-1];
                a = r_acc[k-1];
                r = r_rem[k-1];
                d = r_den[k-1];
                t = r_tag[k-1];
            end
            trial    = {r, a[NW-1]};
            ge       = trial >= {1'b0, d};
            n_rem[k] = ge ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
            n_acc[k] = {a[NW-2:0], ge};
            n_vld[k] = v;
            n_den[k] = d;
            n_tag[k] = t;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NW; k++) r_vld[k] <= n_vld[k];
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_acc[k] <= n_acc[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_tag[k] <= n_tag[k];
            end
        end
    end

    // last stage: valid, quotient, tag
    assign o_q = {r_vld[NW-1], r_acc[NW-1], r_tag[NW-1]};

endmodule

/* src/thermistor_adc_to_celsius_unit.sv */
// thermistor adc sample to resistance and temperature, fully pipelined
//
// Input stream (s side): one beat per adc sample, tdata bits [9:0] hold the sample.
// Output stream (m side): one beat per sample, resistance in 100 ohm units in
// tdata [25:0] and temperature in whole degrees C (signed) in tdata [41:26].
// Configuration goes through the apb port: full scale at 0x0, pull-up resistor
// at 0x4, pull-down resistor at 0x8; a nonzero pull-up selects pull-up mode.
// A sample passes an input register, a multiply stage, a 29-stage divider
// for the resistance, a resistance register, a segment search, a numerator
// stage, a second 29-stage divider for the table interpolation, and the
// output register. Both dividers are bit-per-stage pipes.
// Throughput is one sample per cycle while the receiver keeps tready high.
// Reset clears every stage valid bit and loads the register defaults
// (full scale 1023, pull-up 300, pull-down 0).
// When the receiver holds tready low with a beat waiting, the whole pipe
// freezes and s side tready drops; nothing is lost or repeated.
module thermistor_adc_to_celsius_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [9:0] adc_sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [25:0] resistance, [41:26] temperature_c
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [thrm_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int AW  = thrm_pkg::ADC_W;
    localparam int RW  = thrm_pkg::RES_W;
    localparam int TW  = thrm_pkg::TEMP_W;
    localparam int NW  = thrm_pkg::NUM_W;
    localparam int DW  = thrm_pkg::DEN_W;
    localparam int SW  = thrm_pkg::SEG_W;
    localparam int TGW = thrm_pkg::TAG_W;

    // configuration registers
    logic [AW-1:0] r_full;
    logic [15:0]   r_pu;
    logic [15:0]   r_pd;
    logic          wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= AW'(1023);
            r_pu   <= 16'd300;
            r_pd   <= 16'd0;
        end else if (wr_en) begin
            unique case (i_paddr[3:2])
                thrm_pkg::REG_FULL:     r_full <= i_pwdata[AW-1:0];
                thrm_pkg::REG_PULLUP:   r_pu   <= i_pwdata[15:0];
                thrm_pkg::REG_PULLDOWN: r_pd   <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (i_paddr[3:2])
            thrm_pkg::REG_FULL:     o_prdata = {{(32-AW){1'b0}}, r_full};
            thrm_pkg::REG_PULLUP:   o_prdata = {16'd0, r_pu};
            thrm_pkg::REG_PULLDOWN: o_prdata = {16'd0, r_pd};
            default:                o_prdata = '0;
        endcase
    end

    // pipe advances whenever the output register is free or being taken
    logic r_o_vld;
    logic en;
    assign en         = !r_o_vld || i_m_tready;
    assign o_s_tready = en;

    // input register
    logic          r_s0_vld;
    logic [AW-1:0] r_s0_ad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s0_vld <= 1'b0;
        else if (en)  r_s0_vld <= i_s_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_s0_ad <= i_s_tdata[AW-1:0];
    end

    // divider setup: mode select, clamps and the single multiply
    thrm_pkg::t_div_in r_d1;
    thrm_pkg::t_div_in n_d1;

    always_comb begin
        logic          pu_mode;
        logic [AW-1:0] a;
        logic [AW-1:0] ma;
        logic [15:0]   mb;
        logic [RW-1:0] prod;
        logic          byp;
        logic [RW-1:0] bval;
        logic [AW-1:0] den;
        pu_mode = r_pu != 16'd0;
        a = (r_s0_ad > r_full) ? r_full : r_s0_ad;
        if (a == '0) a = AW'(1);
        if (pu_mode) begin
            ma  = r_s0_ad;
            mb  = r_pu;
            byp = r_s0_ad >= r_full;
            den = r_full - r_s0_ad;
        end else begin
            ma  = r_full - a;
            mb  = r_pd;
            byp = a >= r_full;
            den = a;
        end
        prod = RW'(ma) * RW'(mb);
        bval = pu_mode ? prod : '0;
        if (byp) den = AW'(1);
        n_d1.vld = r_s0_vld;
        n_d1.num = NW'(prod);
        n_d1.den = DW'(den);
        n_d1.tag = {{(TGW-RW-1){1'b0}}, byp, bval};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1.num <= n_d1.num;
            r_d1.den <= n_d1.den;
            r_d1.tag <= n_d1.tag;
        end
        if (!i_rst_n) r_d1.vld <= 1'b0;
        else if (en)  r_d1.vld <= n_d1.vld;
    end

    // resistance divider
    thrm_pkg::t_div_out d1o;

    thrm_div u_div_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_d     (r_d1),
        .o_q     (d1o)
    );

    // resistance register
    logic          r_c_vld;
    logic [RW-1:0] r_c_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else if (en)  r_c_vld <= d1o.vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_c_res <= d1o.tag[RW] ? d1o.tag[RW-1:0] : d1o.quo[RW-1:0];
    end

    // segment search: first point the resistance reaches
    logic          r_e_vld;
    logic [RW-1:0] r_e_res;
    logic [SW-1:0] r_e_seg;
    logic [SW-1:0] n_seg;

    always_comb begin
        n_seg = SW'(thrm_pkg::LAST);
        for (int k = thrm_pkg::LAST - 1; k >= 0; k--) begin
            if (r_c_res >= RW'(thrm_pkg::ROM[k+1])) n_seg = SW'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else if (en)  r_e_vld <= r_c_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_res <= r_c_res;
            r_e_seg <= n_seg;
        end
    end

    // interpolation numerator and segment width
    thrm_pkg::t_div_in r_d2;
    thrm_pkg::t_div_in n_d2;

    always_comb begin
        logic [RW-1:0] diff;
        logic [RW-1:0] lo;
        lo = RW'(thrm_pkg::seg_lo(r_e_seg));
        if (r_e_seg == SW'(thrm_pkg::LAST)) diff = lo - r_e_res;
        else                                diff = r_e_res - lo;
        n_d2.vld = r_e_vld;
        n_d2.num = (NW'(diff) << 2) + NW'(diff);
        n_d2.den = thrm_pkg::seg_den(r_e_seg);
        n_d2.tag = {{(TGW-RW-SW){1'b0}}, r_e_seg, r_e_res};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2.num <= n_d2.num;
            r_d2.den <= n_d2.den;
            r_d2.tag <= n_d2.tag;
        end
        if (!i_rst_n) r_d2.vld <= 1'b0;
        else if (en)  r_d2.vld <= n_d2.vld;
    end

    // interpolation divider
    thrm_pkg::t_div_out d2o;

    thrm_div u_div_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_d     (r_d2),
        .o_q     (d2o)
    );

    // temperature from segment base, then saturation
    logic [RW-1:0] r_o_res;
    logic [TW-1:0] r_o_temp;
    logic [TW-1:0] n_temp;

    always_comb begin
        logic [SW-1:0] seg;
        logic signed [31:0] q;
        logic signed [31:0] deg;
        seg = d2o.tag[RW+SW-1:RW];
        q   = $signed({3'b000, d2o.quo});
        if (seg == SW'(thrm_pkg::LAST)) begin
            deg = 32'(thrm_pkg::BASE_LAST) + q;
        end else begin
            deg = $signed(32'(5) * {27'd0, seg} + 32'(5)) - 32'sd40 - q;
        end
        if (deg > 32'sd32767)       n_temp = 16'h7fff;
        else if (deg < -32'sd32768) n_temp = 16'h8000;
        else                        n_temp = deg[TW-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else if (en)  r_o_vld <= d2o.vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res  <= d2o.tag[RW-1:0];
            r_o_temp <= n_temp;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {6'd0, r_o_temp, r_o_res};

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the thermistor adc to celsius converter
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 64;
    localparam int WDOG_MAX  = 4000;

    localparam int ADC_W     = thrm_pkg::ADC_W;
    localparam int RES_W     = thrm_pkg::RES_W;
    localparam int TEMP_W    = thrm_pkg::TEMP_W;
    localparam int LAST      = thrm_pkg::LAST;
    localparam int BASE_LAST = thrm_pkg::BASE_LAST;

    typedef struct {
        logic [RES_W-1:0]         res;
        logic signed [TEMP_W-1:0] temp;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // [9:0] adc_sample
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // [25:0] resistance, [41:26] temperature_c
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [3:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    // predictor copy of the registers
    logic [ADC_W-1:0] cfg_full;
    logic [15:0]      cfg_pullup;
    logic [15:0]      cfg_pulldown;

    logic [ADC_W-1:0] sample_q[$];
    t_reading         reading_q[$];
    int               errors = 0;
    int               wdog = 0;
    int               src_gap = 0;
    int               sink_gap = 0;
    bit               quiet = 1'b0;
    int               hold_cycles = 0;
    bit               hold_req = 1'b0;

    thermistor_adc_to_celsius_unit u_dut (.*);

    always #10 i_clk = ~i_clk;

    // resistance then table temperature for one sample
    function automatic t_reading predict_reading(input logic [ADC_W-1:0] smp);
        longint unsigned ad, full, r, num, q;
        longint          deg;
        int              seg;
        t_reading        t;
        ad = smp;
        full = cfg_full;
        if (cfg_pullup != 0) begin
            if (ad >= full) r = ad * cfg_pullup;
            else r = (ad * cfg_pullup) / (full - ad);
        end else begin
            if (ad > full) ad = full;
            if (ad == 0) ad = 1;
            if (ad >= full) r = 0;
            else r = ((full - ad) * cfg_pulldown) / ad;
        end
        seg = 0;
        while (seg < LAST && r < thrm_pkg::ROM[seg+1]) seg++;
        if (seg >= LAST) begin
            num = (thrm_pkg::ROM[LAST] - r) * 5;
            deg = longint'(num / (thrm_pkg::ROM[LAST-1] - thrm_pkg::ROM[LAST])) + BASE_LAST;
        end else begin
            num = (r - thrm_pkg::ROM[seg+1]) * 5;
            q = num / (thrm_pkg::ROM[seg] - thrm_pkg::ROM[seg+1]);
            deg = 5 * (seg + 1) - longint'(q) - 40;
        end
        if (deg > 32767) deg = 32767;
        if (deg < -32768) deg = -32768;
        t.res = r[RES_W-1:0];
        t.temp = deg[TEMP_W-1:0];
        return t;
    endfunction

    // input driver: beats from the sample queue with random gaps
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            reading_q.push_back(predict_reading(i_s_tdata[ADC_W-1:0]));
            void'(sample_q.pop_front());
        end
        if (i_s_tvalid && !o_s_tready) begin
            // hold current beat
        end else if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            i_s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            src_gap <= $urandom_range(0, 9);
            i_s_tvalid <= 1'b0;
        end else begin
            // pick next entry, skipping the one just taken
            if ((i_s_tvalid && o_s_tready) ? sample_q.size() > 0 : sample_q.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {6'd0, sample_q[0]};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor with random stalls and one long hold-off
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (o_m_tvalid && i_m_tready) begin
            if (reading_q.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $realtime, o_m_tdata);
                errors++;
            end else begin
                exp_r = reading_q.pop_front();
                if (o_m_tdata[25:0] !== exp_r.res) begin
                    $display("%0t resistance mismatch: expected %0d actual %0d",
                             $realtime, exp_r.res, o_m_tdata[25:0]);
                    errors++;
                end
                if (o_m_tdata[41:26] !== exp_r.temp) begin
                    $display("%0t temperature mismatch: expected %0d actual %0d",
                             $realtime, exp_r.temp, $signed(o_m_tdata[41:26]));
                    errors++;
                end
            end
        end
        if (hold_req && hold_cycles == 0) begin
            hold_cycles <= 300;
            i_m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= (hold_cycles == 1);
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_m_tready <= (sink_gap == 1);
        end else if (i_rst_n && !quiet && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(1, 10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    // register write over apb, block idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (idx)
            thrm_pkg::REG_FULL:     cfg_full = val[ADC_W-1:0];
            thrm_pkg::REG_PULLUP:   cfg_pullup = val[15:0];
            thrm_pkg::REG_PULLDOWN: cfg_pulldown = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || reading_q.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // half the samples near the edges and full scale, the rest anywhere
    function automatic logic [ADC_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return ADC_W'($urandom_range(0, 15));
            1: return ADC_W'($urandom_range(1008, 1023));
            2: return (cfg_full > 8) ? cfg_full - ADC_W'($urandom_range(0, 8)) : cfg_full;
            default: return ADC_W'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin
        logic [ADC_W-1:0] dir_set[] = '{10'd0, 10'd1, 10'd2, 10'd511, 10'd512,
                                        10'd1021, 10'd1022, 10'd1023, 10'h155, 10'h2aa};
        cfg_full = 10'd1023;
        cfg_pullup = 16'd300;
        cfg_pulldown = 16'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset settings, pull-up mode
        foreach (dir_set[k]) sample_q.push_back(dir_set[k]);
        drain();
        // pull-up max resistor, small full scale so samples exceed it
        write_reg(thrm_pkg::REG_PULLUP, 32'hffff);
        write_reg(thrm_pkg::REG_FULL, 32'd1);
        foreach (dir_set[k]) sample_q.push_back(dir_set[k]);
        drain();
        // pull-down mode, zero full scale and then extremes
        write_reg(thrm_pkg::REG_PULLUP, 32'd0);
        write_reg(thrm_pkg::REG_PULLDOWN, 32'hffff);
        write_reg(thrm_pkg::REG_FULL, 32'd0);
        sample_q.push_back(10'd0);
        sample_q.push_back(10'd5);
        drain();
        write_reg(thrm_pkg::REG_FULL, 32'd1023);
        foreach (dir_set[k]) sample_q.push_back(dir_set[k]);
        drain();

        // random phases with random register settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: write_reg(thrm_pkg::REG_PULLUP,
                             $urandom_range(0, 3) == 0 ? 32'd1 : $urandom_range(1, 65535));
                1: write_reg(thrm_pkg::REG_PULLUP, 32'd0);
                default: write_reg(thrm_pkg::REG_PULLUP,
                                   ph == 8 ? 32'hffff : $urandom_range(1, 2000));
            endcase
            write_reg(thrm_pkg::REG_PULLDOWN, ph == 4 ? 32'd0 : $urandom_range(0, 65535));
            write_reg(thrm_pkg::REG_FULL, ph == 7 ? 32'd1 : $urandom_range(1, 1023));
            if (ph == 2) hold_req = 1'b1;
            if (ph == 8) quiet = 1'b1;
            for (int n = 0; n < 200; n++) sample_q.push_back(rand_sample());
            if (ph == 2) begin
                wait (hold_cycles > 0);
                hold_req = 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
